[sv/mrmc_pkg.sv]
// ----------------------------------------------------------------------------
// mrmc_pkg
// Shared types, codes and sizes for the range-match and cell-classify block.
// ----------------------------------------------------------------------------
`default_nettype none

package mrmc_pkg;

  localparam int KEY_BITS      = 64;
  localparam int MAX_DIMS      = 2;
  localparam int KEY_PORTS     = 2;
  localparam int FIELD_BITS    = 64;
  localparam int MODE_BITS     = 3;
  localparam int DIMS_BITS     = 2;
  localparam int OP_BITS       = 2;
  localparam int REL_BITS      = 2;
  localparam int WEIGHT_BITS   = 16;
  localparam int COUNT_BITS    = 32;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 64;

  typedef enum logic [MODE_BITS-1:0] {
    MODE_LESS      = 3'd0,
    MODE_GREATER   = 3'd1,
    MODE_OPEN      = 3'd2,
    MODE_LOW_OPEN  = 3'd3,
    MODE_HIGH_OPEN = 3'd4,
    MODE_CLOSED    = 3'd5
  } mode_t;

  typedef enum logic [OP_BITS-1:0] {
    OP_MATCH    = 2'd0,
    OP_CLASSIFY = 2'd1,
    OP_CLEAR    = 2'd2
  } op_t;

  typedef enum logic [REL_BITS-1:0] {
    REL_OUTSIDE = 2'd0,
    REL_INSIDE  = 2'd1,
    REL_CROSSES = 2'd2
  } rel_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_MODE      = 3'd0,
    CFG_DIMS      = 3'd1,
    CFG_DIM0_LOW  = 3'd2,
    CFG_DIM0_HIGH = 3'd3,
    CFG_DIM1_LOW  = 3'd4,
    CFG_DIM1_HIGH = 3'd5
  } cfg_idx_t;

  typedef logic [KEY_BITS-1:0] key_t;

  typedef struct packed {
    logic [MODE_BITS-1:0] mode;
    logic [DIMS_BITS-1:0] dims;
    key_t [KEY_PORTS-1:0] low;
    key_t [KEY_PORTS-1:0] high;
  } cfg_t;

  typedef struct packed {
    logic point_ok;
    logic cell_out;
    logic cell_cross;
  } dim_res_t;

endpackage

`default_nettype wire

[sv/multidim_range_match_classify.sv]
// ----------------------------------------------------------------------------
// multidim_range_match_classify
// Range-query visitor: point match with saturating hit count, cell classify, count clear.
// ----------------------------------------------------------------------------
//   channel | direction | handshake         | payload
//   in_     | input     | in_valid/in_stall | operation, keys, row_weight
//   out_    | output    | out_valid/out_stall | is_match, relation, hit_total
//   cfg_    | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One request per cycle while out_stall is low; input register to result
// register, through the per-dimension comparators and the counter add.
// Synchronous active-low reset clears valids and counter, loads default config.
// The input register acts as a skid stage: a request is taken while a
// stalled result waits, and in_stall rises only when both stages are full.
// ----------------------------------------------------------------------------
`default_nettype none

module multidim_range_match_classify
  import mrmc_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [OP_BITS-1:0]       in_operation,
  input  wire logic [FIELD_BITS-1:0]    in_first_dim0,
  input  wire logic [FIELD_BITS-1:0]    in_first_dim1,
  input  wire logic [FIELD_BITS-1:0]    in_second_dim0,
  input  wire logic [FIELD_BITS-1:0]    in_second_dim1,
  input  wire logic [WEIGHT_BITS-1:0]   in_row_weight,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic                          out_is_match,
  output logic [REL_BITS-1:0]           out_relation,
  output logic [COUNT_BITS-1:0]         out_hit_total,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_data
);

  cfg_t cfg;

  assign cfg_ready = 1'b1;

  mrmc_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_valid && cfg_ready),
    .wr_idx  (cfg_index),
    .wr_data (cfg_data),
    .cfg     (cfg)
  );

  logic                   s1_valid_r;
  logic [OP_BITS-1:0]     s1_op_r;
  key_t [KEY_PORTS-1:0]   s1_first_r;
  key_t [KEY_PORTS-1:0]   s1_second_r;
  logic [WEIGHT_BITS-1:0] s1_weight_r;

  logic                   out_valid_r;
  logic                   is_match_r, is_match_nxt;
  logic [REL_BITS-1:0]    relation_r, relation_nxt;
  logic [COUNT_BITS-1:0]  count_r, count_nxt;

  logic adv, s1_load;

  assign adv      = !out_valid_r || !out_stall;
  assign s1_load  = !s1_valid_r || adv;
  assign in_stall = !s1_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_load) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load && in_valid) begin
      s1_op_r        <= in_operation;
      s1_first_r[0]  <= in_first_dim0[KEY_BITS-1:0];
      s1_first_r[1]  <= in_first_dim1[KEY_BITS-1:0];
      s1_second_r[0] <= in_second_dim0[KEY_BITS-1:0];
      s1_second_r[1] <= in_second_dim1[KEY_BITS-1:0];
      s1_weight_r    <= in_row_weight;
    end
  end

  dim_res_t [MAX_DIMS-1:0] dres;
  logic     [MAX_DIMS-1:0] dim_en, dim_ok, dim_out, dim_cross;

  for (genvar d = 0; d < MAX_DIMS; d++) begin : g_dim
    mrmc_dim_cmp u_cmp (
      .mode   (cfg.mode),
      .lo     (cfg.low[d]),
      .hi     (cfg.high[d]),
      .first  (s1_first_r[d]),
      .second (s1_second_r[d]),
      .res    (dres[d])
    );
    if (d == 0) begin : g_first
      assign dim_en[d] = 1'b1;
    end else begin : g_rest
      assign dim_en[d] = cfg.dims > DIMS_BITS'(d);
    end
    assign dim_ok[d]    = dres[d].point_ok || !dim_en[d];
    assign dim_out[d]   = dres[d].cell_out && dim_en[d];
    assign dim_cross[d] = dres[d].cell_cross && dim_en[d];
  end

  logic [COUNT_BITS:0] sum;

  assign sum = {1'b0, count_r} + (COUNT_BITS + 1)'(s1_weight_r);

  always_comb begin
    is_match_nxt = 1'b0;
    relation_nxt = REL_OUTSIDE;
    count_nxt    = count_r;
    case (s1_op_r)
      OP_MATCH: begin
        if (&dim_ok) begin
          is_match_nxt = 1'b1;
          count_nxt    = sum[COUNT_BITS] ? '1 : sum[COUNT_BITS-1:0];
        end
      end
      OP_CLASSIFY: begin
        if (|dim_out) begin
          relation_nxt = REL_OUTSIDE;
        end else if (|dim_cross) begin
          relation_nxt = REL_CROSSES;
        end else begin
          relation_nxt = REL_INSIDE;
        end
      end
      OP_CLEAR: count_nxt = '0;
      default:  count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r;
      if (s1_valid_r) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid_r) begin
      is_match_r <= is_match_nxt;
      relation_r <= relation_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_is_match  = is_match_r;
  assign out_relation  = relation_r;
  assign out_hit_total = count_r;

endmodule

`default_nettype wire

[sv/mrmc_cfg_regs.sv]
// ----------------------------------------------------------------------------
// mrmc_cfg_regs
// Query configuration registers: compare mode, dimension count and bounds.
// ----------------------------------------------------------------------------
`default_nettype none

module mrmc_cfg_regs
  import mrmc_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     wr_en,
  input  wire logic [CFG_IDX_BITS-1:0]  wr_idx,
  input  wire logic [CFG_DATA_BITS-1:0] wr_data,
  output cfg_t                          cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_idx)
        CFG_MODE:      cfg_nxt.mode    = wr_data[MODE_BITS-1:0];
        CFG_DIMS:      cfg_nxt.dims    = wr_data[DIMS_BITS-1:0];
        CFG_DIM0_LOW:  cfg_nxt.low[0]  = wr_data[KEY_BITS-1:0];
        CFG_DIM0_HIGH: cfg_nxt.high[0] = wr_data[KEY_BITS-1:0];
        CFG_DIM1_LOW:  cfg_nxt.low[1]  = wr_data[KEY_BITS-1:0];
        CFG_DIM1_HIGH: cfg_nxt.high[1] = wr_data[KEY_BITS-1:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode <= MODE_CLOSED;
      cfg_r.dims <= DIMS_BITS'(1);
      cfg_r.low  <= '0;
      cfg_r.high <= '1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

[sv/mrmc_dim_cmp.sv]
// ----------------------------------------------------------------------------
// mrmc_dim_cmp
// One dimension's bound compare for point match and cell classify.
// ----------------------------------------------------------------------------
`default_nettype none

module mrmc_dim_cmp
  import mrmc_pkg::*;
(
  input  wire logic [MODE_BITS-1:0] mode,
  input  wire key_t                 lo,
  input  wire key_t                 hi,
  input  wire key_t                 first,
  input  wire key_t                 second,
  output dim_res_t                  res
);

  logic a_gt_lo, a_lt_lo, a_gt_hi, a_lt_hi;
  logic b_lt_lo, b_gt_hi, b_gt_lo, b_lt_hi;

  assign a_gt_lo = first > lo;
  assign a_lt_lo = first < lo;
  assign a_gt_hi = first > hi;
  assign a_lt_hi = first < hi;
  assign b_lt_lo = second < lo;
  assign b_gt_hi = second > hi;
  assign b_gt_lo = second > lo;
  assign b_lt_hi = second < hi;

  always_comb begin
    case (mode)
      MODE_LESS:      res.point_ok = a_lt_hi;
      MODE_GREATER:   res.point_ok = a_gt_lo;
      MODE_OPEN:      res.point_ok = a_gt_lo && a_lt_hi;
      MODE_LOW_OPEN:  res.point_ok = a_gt_lo && !a_gt_hi;
      MODE_HIGH_OPEN: res.point_ok = !a_lt_lo && a_lt_hi;
      default:        res.point_ok = !a_lt_lo && !a_gt_hi;
    endcase
    case (mode)
      MODE_LESS: begin
        res.cell_out   = !a_lt_hi;
        res.cell_cross = !a_gt_lo || !b_lt_hi;
      end
      MODE_GREATER: begin
        res.cell_out   = !b_gt_lo;
        res.cell_cross = !a_gt_lo || !b_lt_hi;
      end
      default: begin
        res.cell_out   = a_gt_hi || b_lt_lo;
        res.cell_cross = a_lt_lo || b_gt_hi;
      end
    endcase
  end

endmodule

`default_nettype wire
